/* rtl/core/gtcp_pkg.sv */
// ----------------------------------------------------------------------------
// gtcp_pkg
// Shared types and constants for the GPIO text command parser.
// ----------------------------------------------------------------------------
package gtcp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_WRITE_OK  = 3'd0,
    ST_READ_OK   = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_BAD_PORT  = 3'd3,
    ST_BAD_PIN   = 3'd4,
    ST_BAD_VALUE = 3'd5,
    ST_BAD_CMD   = 3'd6
  } status_e;

  // ASCII characters used by the command grammar
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChQuery  = 8'h3F;
  localparam logic [7:0] ChEquals = 8'h3D;

  // Number of leading characters kept per command, and count ceiling
  localparam int unsigned HeldChars = 4;
  localparam logic [2:0]  CountMax  = 3'd7;

  // Fixed widths of the bank view on the ports
  localparam int unsigned BankBits  = 48;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned MaxPorts  = 8;
  localparam int unsigned WideBits  = MaxPorts * ByteBits;

  // Decoded command, passed from the decoder to the port bank
  typedef struct packed {
    status_e    status;
    logic [2:0] port;
    logic [2:0] pin;
    logic [7:0] echo;
    logic       do_read;
    logic       do_write;
    logic       level;
  } cmd_op_t;

endpackage

/* rtl/core/gtcp_decode.sv */
// ----------------------------------------------------------------------------
// gtcp_decode
// Checks the form of a finished command and decodes port, pin and action.
// ----------------------------------------------------------------------------
module gtcp_decode import gtcp_pkg::*; #(
  parameter int unsigned NUM_PORTS     = 6,
  parameter int unsigned PINS_PER_PORT = 8
) (
  input  logic [2:0] count_i,
  input  logic [7:0] c0_i,
  input  logic [7:0] c1_i,
  input  logic [7:0] c2_i,
  input  logic [7:0] c3_i,
  output cmd_op_t    op_o
);

  logic       upper_hit;
  logic       lower_hit;
  logic [7:0] port_off;
  logic       port_ok;
  logic [7:0] pin_off;
  logic       pin_ok;

  // Port letter, either case
  assign upper_hit = (c0_i >= ChUpperA) && (c0_i <= ChUpperF);
  assign lower_hit = (c0_i >= ChLowerA) && (c0_i <= ChLowerF);
  assign port_off  = upper_hit ? (c0_i - ChUpperA) : (c0_i - ChLowerA);
  assign port_ok   = (upper_hit || lower_hit) &&
                     ({1'b0, port_off[2:0]} < 4'(NUM_PORTS));

  // Pin digit
  assign pin_off = c1_i - ChZero;
  assign pin_ok  = (c1_i >= ChZero) && (c1_i <= ChSeven) &&
                   ({1'b0, pin_off[2:0]} < 4'(PINS_PER_PORT));

  // Form check, in priority order
  always_comb begin
    op_o          = '0;
    op_o.status   = ST_WRITE_OK;
    if (count_i < 3'd3) begin
      op_o.status = ST_TOO_SHORT;
    end else if (!port_ok) begin
      op_o.status = ST_BAD_PORT;
      op_o.echo   = c0_i;
    end else if (!pin_ok) begin
      op_o.status = ST_BAD_PIN;
      op_o.port   = port_off[2:0];
      op_o.echo   = c1_i;
    end else begin
      op_o.port = port_off[2:0];
      op_o.pin  = pin_off[2:0];
      if (c2_i == ChQuery) begin
        op_o.status  = ST_READ_OK;
        op_o.do_read = 1'b1;
      end else if ((count_i >= 3'd4) && (c2_i == ChEquals)) begin
        if ((c3_i == ChZero) || (c3_i == ChOne)) begin
          op_o.status   = ST_WRITE_OK;
          op_o.do_write = 1'b1;
          op_o.level    = (c3_i == ChOne);
        end else begin
          op_o.status = ST_BAD_VALUE;
          op_o.echo   = c3_i;
        end
      end else begin
        op_o.status = ST_BAD_CMD;
        op_o.echo   = c0_i;
      end
    end
  end

endmodule

/* rtl/core/gtcp_bank.sv */
// ----------------------------------------------------------------------------
// gtcp_bank
// Direction and output-level bytes of the GPIO ports, plus pin read-back.
// ----------------------------------------------------------------------------
module gtcp_bank import gtcp_pkg::*; #(
  parameter int unsigned NUM_PORTS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                apply_i,
  input  cmd_op_t             op_i,
  input  logic [BankBits-1:0] pin_levels_i,
  output logic                read_value_o,
  output logic [BankBits-1:0] dir_next_o,
  output logic [BankBits-1:0] lvl_next_o
);

  logic [ByteBits-1:0] dir_q [NUM_PORTS];
  logic [ByteBits-1:0] lvl_q [NUM_PORTS];
  logic [ByteBits-1:0] dir_d [NUM_PORTS];
  logic [ByteBits-1:0] lvl_d [NUM_PORTS];
  logic [ByteBits-1:0] pin_bit;
  logic [WideBits-1:0] levels_wide;
  logic [WideBits-1:0] dir_wide;
  logic [WideBits-1:0] lvl_wide;

  assign pin_bit = ByteBits'(1) << op_i.pin;

  // Next bank contents for the current command
  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      dir_d[p] = dir_q[p];
      lvl_d[p] = lvl_q[p];
      if (apply_i && (op_i.port == 3'(p))) begin
        if (op_i.do_read) begin
          dir_d[p] = dir_q[p] & ~pin_bit;
        end else if (op_i.do_write) begin
          dir_d[p] = dir_q[p] | pin_bit;
          lvl_d[p] = op_i.level ? (lvl_q[p] | pin_bit) : (lvl_q[p] & ~pin_bit);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        dir_q[p] <= '0;
        lvl_q[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        dir_q[p] <= dir_d[p];
        lvl_q[p] <= lvl_d[p];
      end
    end
  end

  // Pack bytes, port p at bits 8p..8p+7; bits past the port view drop out
  always_comb begin
    dir_wide = '0;
    lvl_wide = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      dir_wide[ByteBits*p +: ByteBits] = dir_d[p];
      lvl_wide[ByteBits*p +: ByteBits] = lvl_d[p];
    end
  end

  assign dir_next_o = dir_wide[BankBits-1:0];
  assign lvl_next_o = lvl_wide[BankBits-1:0];

  // Sampled level of the addressed pin
  assign levels_wide  = {{(WideBits-BankBits){1'b0}}, pin_levels_i};
  assign read_value_o = op_i.do_read & levels_wide[{op_i.port, op_i.pin}];

endmodule

/* rtl/core/gpio_text_command_parser_top.sv */
// ----------------------------------------------------------------------------
// gpio_text_command_parser_top
// Character-serial GPIO command parser with a six-port direction/level bank.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-----------------------------------
//   input   | in_valid_i | in_stall_o  | cmd_char_i, end_of_command_i,
//           |            |             | pin_levels_i
//   result  | out_valid_o| out_stall_i | status_o, read_value_o, port_index_o,
//           |            |             | pin_index_o, echo_char_o,
//           |            |             | direction_bits_o, level_bits_o
//
// One character per cycle unless stalled: input register, decode and bank
// update, then the result register. A result is valid once its end
// character has passed the input register and then the result register.
// A character without the end mark never waits on the result side; the end
// character holds in the input register while a result still sits unread.
// Reset clears held characters, count, all directions (inputs) and levels.
// ----------------------------------------------------------------------------
module gpio_text_command_parser_top import gtcp_pkg::*; #(
  parameter int unsigned NUM_PORTS     = 6,
  parameter int unsigned PINS_PER_PORT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          cmd_char_i,
  input  logic                end_of_command_i,
  input  logic [BankBits-1:0] pin_levels_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic                read_value_o,
  output logic [2:0]          port_index_o,
  output logic [2:0]          pin_index_o,
  output logic [7:0]          echo_char_o,
  output logic [BankBits-1:0] direction_bits_o,
  output logic [BankBits-1:0] level_bits_o
);

  // Input register
  logic                in_vld_q;
  logic [7:0]          char_q;
  logic                last_q;
  logic [BankBits-1:0] levels_q;

  // Command gathering state
  logic [7:0] held_q [HeldChars];
  logic [2:0] count_q;
  logic [2:0] count_d;
  logic [2:0] count_inc;
  logic [7:0] view [HeldChars];

  // Result register
  logic                out_vld_q;
  cmd_op_t             res_q;
  logic                rval_q;
  logic [BankBits-1:0] dir_q;
  logic [BankBits-1:0] lvl_q;

  logic                out_free;
  logic                advance;
  logic                in_take;
  logic                apply;
  cmd_op_t             op;
  logic                rval;
  logic [BankBits-1:0] dir_next;
  logic [BankBits-1:0] lvl_next;

  // Flow control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!last_q || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign apply      = advance && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q   <= cmd_char_i;
      last_q   <= end_of_command_i;
      levels_q <= pin_levels_i;
    end
  end

  // Characters as seen including the one being processed
  always_comb begin
    for (int i = 0; i < HeldChars; i++) begin
      view[i] = (count_q == 3'(i)) ? char_q : held_q[i];
    end
  end

  assign count_inc = (count_q == CountMax) ? CountMax : count_q + 3'd1;
  assign count_d   = last_q ? 3'd0 : count_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < HeldChars; i++) begin
        held_q[i] <= '0;
      end
    end else if (advance) begin
      count_q <= count_d;
      if (count_q < 3'(HeldChars)) begin
        held_q[count_q[1:0]] <= char_q;
      end
    end
  end

  gtcp_decode #(
    .NUM_PORTS    (NUM_PORTS),
    .PINS_PER_PORT(PINS_PER_PORT)
  ) u_decode (
    .count_i(count_inc),
    .c0_i   (view[0]),
    .c1_i   (view[1]),
    .c2_i   (view[2]),
    .c3_i   (view[3]),
    .op_o   (op)
  );

  gtcp_bank #(
    .NUM_PORTS(NUM_PORTS)
  ) u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .apply_i     (apply),
    .op_i        (op),
    .pin_levels_i(levels_q),
    .read_value_o(rval),
    .dir_next_o  (dir_next),
    .lvl_next_o  (lvl_next)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (apply) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      res_q  <= op;
      rval_q <= rval;
      dir_q  <= dir_next;
      lvl_q  <= lvl_next;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = res_q.status;
  assign read_value_o     = rval_q;
  assign port_index_o     = res_q.port;
  assign pin_index_o      = res_q.pin;
  assign echo_char_o      = res_q.echo;
  assign direction_bits_o = dir_q;
  assign level_bits_o     = lvl_q;

endmodule
